FILE: hdl/speed_adaptive_position_ema_macros.svh
// Assertion macros for the speed-adaptive position smoothing block
`ifndef SPEED_ADAPTIVE_POSITION_EMA_MACROS_SVH
`define SPEED_ADAPTIVE_POSITION_EMA_MACROS_SVH

// same-cycle implication
`define SAPE_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define SAPE_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/sape_pkg.sv
// Shared types and constants for the speed-adaptive position smoothing block
package sape_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int ALT_W   = 25;
    localparam int SPEED_W = 16;
    localparam int AREG_W  = 17;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 88;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ALPHA = 2'd2;

    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd5000;
    localparam logic [AREG_W-1:0]  MIN_ALPHA_RST = 17'd6554;
    localparam logic [AREG_W-1:0]  MAX_ALPHA_RST = 17'd52429;
    localparam logic [AREG_W-1:0]  AREG_ONE      = 17'd65536;

    typedef struct packed {
        logic                       load;
        logic signed [LAT_W-1:0]    latitude;
        logic signed [LON_W-1:0]    longitude;
        logic signed [ALT_W-1:0]    altitude;
        logic [SPEED_W-1:0]         ground_speed;
    } item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] max_speed;
        logic [AREG_W-1:0]  min_alpha;
        logic [AREG_W-1:0]  max_alpha;
    } cfg_t;

endpackage

FILE: hdl/sape_front.sv
// Input acceptance, first-fix tagging and two-entry item queue
module sape_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [sape_pkg::IN_W-1:0] s_tdata,
    output logic                   q_valid,
    input  logic                   q_ready,
    output sape_pkg::item_t        q_item
);
    import sape_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        primed_reg;
    logic        push;
    logic        pop;
    item_t       in_item;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        in_item.load         = !primed_reg;
        in_item.latitude     = s_tdata[30:0];
        in_item.longitude    = s_tdata[62:31];
        in_item.altitude     = s_tdata[87:63];
        in_item.ground_speed = s_tdata[103:88];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            primed_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                primed_reg <= 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/sape_div.sv
// Bit-serial restoring divider for the smoothing weight
module sape_div
#(
    parameter int DVD_W = 34,
    parameter int QUO_W = 17
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [DVD_W-1:0]                dividend,
    input  logic [sape_pkg::SPEED_W-1:0]    divisor,
    output logic                            done,
    output logic [QUO_W-1:0]                quotient
);
    import sape_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]   dvd_reg;
    logic [SPEED_W-1:0] rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SPEED_W:0]   trial;
    logic               qbit;
    logic [SPEED_W:0]   diff;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit     = (trial >= {1'b0, divisor});
    assign diff     = trial - {1'b0, divisor};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= qbit ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg  <= CW'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: hdl/sape_back.sv
// Weight computation, coordinate blending and output register
module sape_back
#(
    parameter int ALPHA_FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sape_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  sape_pkg::item_t             q_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sape_pkg::OUT_W-1:0]  m_tdata
);
    import sape_pkg::*;

    localparam int F     = ALPHA_FRAC_BITS;
    localparam int AW    = F + 1;
    localparam int DVD_W = F + 18;
    localparam int NW    = F + 34;
    localparam int PW    = F + 35;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_PROD  = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [1:0] LANE_LAT = 2'd0;
    localparam logic [1:0] LANE_LON = 2'd1;
    localparam logic [1:0] LANE_ALT = 2'd2;

    logic [2:0]              state_reg;
    logic [1:0]              lane_reg;
    item_t                   item_reg;
    logic signed [LAT_W-1:0] filt_lat_reg;
    logic signed [LON_W-1:0] filt_lon_reg;
    logic signed [ALT_W-1:0] filt_alt_reg;
    logic [SPEED_W-1:0]      ms_reg;
    logic [32:0]             plo_reg;
    logic [32:0]             phi_reg;
    logic [32:0]             num_reg;
    logic [AW-1:0]           alpha_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic [AREG_W-1:0]       lo_alpha;
    logic [AREG_W-1:0]       hi_alpha;
    logic [SPEED_W-1:0]      ms_eff;
    logic [SPEED_W-1:0]      s_eff;
    logic [NW-1:0]           n_full;
    logic [DVD_W-1:0]        dividend;
    logic                    div_done;
    logic [AW-1:0]           quotient;
    logic signed [32:0]      filt_sel;
    logic signed [32:0]      meas_sel;
    logic signed [32:0]      diff;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    rnd;
    logic signed [PW-1:0]    step;
    logic signed [32:0]      filt_next;
    logic                    out_free;

    assign lo_alpha = (cfg.min_alpha > AREG_ONE) ? AREG_ONE : cfg.min_alpha;
    assign hi_alpha = (cfg.max_alpha > AREG_ONE) ? AREG_ONE : cfg.max_alpha;

    always_comb
    begin
        if (cfg.max_speed == '0)
        begin
            ms_eff = SPEED_W'(1);
            s_eff  = SPEED_W'(1);
        end
        else
        begin
            ms_eff = cfg.max_speed;
            s_eff  = (item_reg.ground_speed < cfg.max_speed) ? item_reg.ground_speed
                                                             : cfg.max_speed;
        end
    end

    assign n_full   = (NW'(num_reg) << F) + (NW'(ms_reg) << 15);
    assign dividend = n_full[NW-1:16];

    sape_div
    #(
        .DVD_W (DVD_W),
        .QUO_W (AW)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .dividend (dividend),
        .divisor  (ms_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        case (lane_reg)
            LANE_LAT:
            begin
                filt_sel = 33'(filt_lat_reg);
                meas_sel = 33'(item_reg.latitude);
            end
            LANE_LON:
            begin
                filt_sel = 33'(filt_lon_reg);
                meas_sel = 33'(item_reg.longitude);
            end
            default:
            begin
                filt_sel = 33'(filt_alt_reg);
                meas_sel = 33'(item_reg.altitude);
            end
        endcase
    end

    assign diff      = meas_sel - filt_sel;
    assign prod_next = PW'($signed({1'b0, alpha_reg})) * PW'(diff);
    assign rnd       = prod_reg + HALF;
    assign step      = rnd >>> F;
    assign filt_next = filt_sel + 33'(step);

    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg <= q_item;
                if (q_valid && q_item.load)
                begin
                    filt_lat_reg <= q_item.latitude;
                    filt_lon_reg <= q_item.longitude;
                    filt_alt_reg <= q_item.altitude;
                end
            end
            ST_MUL:
            begin
                ms_reg  <= ms_eff;
                plo_reg <= 33'(lo_alpha) * 33'(ms_eff - s_eff);
                phi_reg <= 33'(hi_alpha) * 33'(s_eff);
            end
            ST_SUM:
            begin
                num_reg <= plo_reg + phi_reg;
            end
            ST_DIV:
            begin
                alpha_reg <= quotient;
            end
            ST_PROD:
            begin
                prod_reg <= prod_next;
            end
            ST_ACC:
            begin
                case (lane_reg)
                    LANE_LAT: filt_lat_reg <= filt_next[LAT_W-1:0];
                    LANE_LON: filt_lon_reg <= filt_next[LON_W-1:0];
                    default:  filt_alt_reg <= filt_next[ALT_W-1:0];
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= {filt_alt_reg, filt_lon_reg, filt_lat_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lane_reg      <= LANE_LAT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= q_item.load ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL:   state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_START;
                ST_START: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        lane_reg  <= LANE_LAT;
                        state_reg <= ST_PROD;
                    end
                end
                ST_PROD:  state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (lane_reg == LANE_ALT)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + 2'd1;
                        state_reg <= ST_PROD;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/speed_adaptive_position_ema.sv
// Top level of the speed-adaptive position smoothing block
//
// Smooths a stream of position fixes with an exponential moving average whose
// weight follows ground speed. One result transfer comes out per fix. The first
// fix after reset passes straight through. Every later fix goes through the
// bit-serial divider that forms the weight, one quotient bit per cycle, followed
// by one shared multiplier that blends the three coordinates in turn. A two-entry
// queue takes new fixes while one is being worked on, and the output register
// holds a finished result until it is taken. Configuration writes are accepted
// every cycle; write them only while no fix is in flight.
module speed_adaptive_position_ema
#(
    parameter int ALPHA_FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // latitude[30:0], longitude[62:31], altitude[87:63], ground_speed[103:88]
    input  logic [sape_pkg::IN_W-1:0]        s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // smoothed_latitude[30:0], smoothed_longitude[62:31], smoothed_altitude[87:63]
    output logic [sape_pkg::OUT_W-1:0]       m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sape_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sape_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sape_pkg::*;

    `include "speed_adaptive_position_ema_macros.svh"

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed <= MAX_SPEED_RST;
            cfg_reg.min_alpha <= MIN_ALPHA_RST;
            cfg_reg.max_alpha <= MAX_ALPHA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_SPEED: cfg_reg.max_speed <= cfg_data[SPEED_W-1:0];
                REG_MIN_ALPHA: cfg_reg.min_alpha <= cfg_data;
                REG_MAX_ALPHA: cfg_reg.max_alpha <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sape_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sape_back
    #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `SAPE_ASSERT_NOW(a_full_queue_valid, clk, rst_n, !s_tready, q_valid, "input stalled with empty queue")
    `SAPE_ASSERT_NEXT(a_push_visible, clk, rst_n, s_tvalid && s_tready, q_valid, "accepted fix not queued")
    `SAPE_ASSERT_NEXT(a_pop_busy, clk, rst_n, q_valid && q_ready, !q_ready, "back end took two fixes in a row")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the speed-adaptive position smoothing block
module testbench;
    import sape_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_FIXES = 1350;
    localparam int PHASE_FIXES  = 170;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint LAT_LO   = -(64'sd1 <<< (LAT_W - 1));
    localparam longint LAT_HI   = (64'sd1 <<< (LAT_W - 1)) - 1;
    localparam longint LON_LO   = -(64'sd1 <<< (LON_W - 1));
    localparam longint LON_HI   = (64'sd1 <<< (LON_W - 1)) - 1;
    localparam longint ALT_LO   = -(64'sd1 <<< (ALT_W - 1));
    localparam longint ALT_HI   = (64'sd1 <<< (ALT_W - 1)) - 1;
    localparam int     SPEED_HI = 65535;

    typedef struct packed {
        logic [SPEED_W-1:0]      ground_speed;
        logic signed [ALT_W-1:0] altitude;
        logic signed [LON_W-1:0] longitude;
        logic signed [LAT_W-1:0] latitude;
    } fix_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] altitude;
        logic signed [LON_W-1:0] longitude;
        logic signed [LAT_W-1:0] latitude;
    } position_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [SPEED_W-1:0] top_speed   = MAX_SPEED_RST;
    logic [AREG_W-1:0]  slow_weight = MIN_ALPHA_RST;
    logic [AREG_W-1:0]  fast_weight = MAX_ALPHA_RST;

    longint track_lat;
    longint track_lon;
    longint track_alt;
    bit     track_loaded = 1'b0;

    position_t expected_positions[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 14;
    int sink_idle_pct = 14;
    int sink_hold     = 0;

    speed_adaptive_position_ema #(
        .ALPHA_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic longint speed_weight(logic [SPEED_W-1:0] speed);
        longint unsigned span;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned s;
        longint unsigned num;
        longint unsigned den;
        span = 64'(top_speed);
        lo = 64'((slow_weight > AREG_ONE) ? AREG_ONE : slow_weight);
        hi = 64'((fast_weight > AREG_ONE) ? AREG_ONE : fast_weight);
        if (span == 0)
        begin
            span = 1;
            s = 1;
        end
        else
            s = (64'(speed) < span) ? 64'(speed) : span;
        num = lo * (span - s) + hi * s;
        den = span << 16;
        return longint'(((num << FRAC_BITS) + (den >> 1)) / den);
    endfunction

    // floor of the scaled sum, which is round to nearest with ties upward
    function automatic longint blend_toward(longint held, longint meas, longint w);
        longint sum;
        sum = ((64'sd1 <<< FRAC_BITS) - w) * held + w * meas + (64'sd1 <<< (FRAC_BITS - 1));
        return sum >>> FRAC_BITS;
    endfunction

    always @(posedge clk)
    begin
        position_t got;
        position_t want;
        fix_t      f;
        longint    w;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_positions.size() == 0)
            begin
                $error("result transfer with no fix outstanding");
                error_count++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (got.latitude !== want.latitude)
                begin
                    $error("smoothed_latitude: expected %0d, actual %0d",
                           want.latitude, got.latitude);
                    error_count++;
                end
                if (got.longitude !== want.longitude)
                begin
                    $error("smoothed_longitude: expected %0d, actual %0d",
                           want.longitude, got.longitude);
                    error_count++;
                end
                if (got.altitude !== want.altitude)
                begin
                    $error("smoothed_altitude: expected %0d, actual %0d",
                           want.altitude, got.altitude);
                    error_count++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            f = s_tdata;
            if (!track_loaded)
            begin
                track_lat = longint'(f.latitude);
                track_lon = longint'(f.longitude);
                track_alt = longint'(f.altitude);
                track_loaded = 1'b1;
            end
            else
            begin
                w = speed_weight(f.ground_speed);
                track_lat = blend_toward(track_lat, longint'(f.latitude), w);
                track_lon = blend_toward(track_lon, longint'(f.longitude), w);
                track_alt = blend_toward(track_alt, longint'(f.altitude), w);
            end
            want.latitude  = track_lat[LAT_W-1:0];
            want.longitude = track_lon[LON_W-1:0];
            want.altitude  = track_alt[ALT_W-1:0];
            expected_positions.push_back(want);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_SPEED: top_speed = cfg_data[SPEED_W-1:0];
                REG_MIN_ALPHA: slow_weight = cfg_data[AREG_W-1:0];
                REG_MAX_ALPHA: fast_weight = cfg_data[AREG_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic fix_t make_fix(longint lat, longint lon, longint alt, int speed);
        fix_t f;
        f.latitude     = lat[LAT_W-1:0];
        f.longitude    = lon[LON_W-1:0];
        f.altitude     = alt[ALT_W-1:0];
        f.ground_speed = speed[SPEED_W-1:0];
        return f;
    endfunction

    function automatic fix_t random_fix();
        fix_t f;
        f.latitude     = LAT_W'($urandom);
        f.longitude    = $urandom;
        f.altitude     = ALT_W'($urandom);
        f.ground_speed = SPEED_W'($urandom);
        return f;
    endfunction

    function automatic int pick_speed();
        if ($urandom_range(3) == 0)
            return $urandom_range(SPEED_HI);
        return $urandom_range(int'(top_speed));
    endfunction

    function automatic fix_t route_start();
        return make_fix(longint'($urandom_range(1800000000)) - 900000000,
                        longint'($urandom_range(32'd3600000000)) - 1800000000,
                        longint'($urandom_range(10100000)) - 100000,
                        pick_speed());
    endfunction

    function automatic fix_t route_step(fix_t f);
        return make_fix(longint'(f.latitude) + $urandom_range(4000) - 2000,
                        longint'(f.longitude) + $urandom_range(4000) - 2000,
                        longint'(f.altitude) + $urandom_range(1000) - 500,
                        pick_speed());
    endfunction

    task automatic send_fix(fix_t f);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= f;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_positions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(int speed, int lo, int hi);
        drain();
        write_reg(REG_MAX_SPEED, CFG_DATA_W'(speed));
        write_reg(REG_MIN_ALPHA, CFG_DATA_W'(lo));
        write_reg(REG_MAX_ALPHA, CFG_DATA_W'(hi));
    endtask

    function automatic int random_alpha_reg();
        case ($urandom_range(6))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(131071, 65537);
            default: return $urandom_range(65536);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_fix(make_fix(LAT_LO, LON_HI, ALT_LO, SPEED_HI));
        send_fix(make_fix(LAT_HI, LON_LO, ALT_HI, 0));
        send_fix(make_fix(LAT_LO, LON_HI, ALT_LO, 5000));
        send_fix(make_fix(123456789, -987654321, 250000, 2500));
        send_fix(make_fix(0, 0, 0, 1));
        send_fix(make_fix(-1, -1, -1, 4999));
        drain();
    endtask

    task automatic test_config_corners();
        set_limits(0, 0, 65536);
        send_fix(make_fix(LAT_HI, LON_HI, ALT_HI, 0));
        send_fix(make_fix(-5, 7, -9, SPEED_HI));
        set_limits(SPEED_HI, 131071, 0);
        send_fix(make_fix(LAT_LO, LON_LO, ALT_LO, 0));
        send_fix(make_fix(LAT_HI, LON_HI, ALT_HI, SPEED_HI));
        send_fix(make_fix(LAT_HI, LON_HI, ALT_HI, 32768));
        drain();
        write_reg(REG_UNUSED, 17'h1FFFF);
        send_fix(make_fix(1000, -1000, 1000, SPEED_HI));
        set_limits(1, 0, 65537);
        send_fix(make_fix(LAT_LO, LON_HI, ALT_HI, 0));
        send_fix(make_fix(LAT_LO, LON_HI, ALT_LO, 1));
        set_limits(3, 65536, 1);
        send_fix(make_fix(LAT_HI, LON_LO, ALT_HI, 1));
        send_fix(make_fix(-77, 77, -77, 2));
        drain();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_hold = 600;
        for (int i = 0; i < 20; i++)
            send_fix(random_fix());
        drain();
        for (int i = 0; i < 4; i++)
            send_fix(random_fix());
        drain();
        src_idle_pct = 14;
    endtask

    task automatic test_random_stream();
        int   sent;
        int   phase;
        int   phase_end;
        int   run_len;
        int   speed;
        fix_t f;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_FIXES)
        begin
            case ($urandom_range(5))
                0: speed = 0;
                1: speed = 1;
                2: speed = SPEED_HI;
                default: speed = $urandom_range(12000, 1);
            endcase
            set_limits(speed, random_alpha_reg(), random_alpha_reg());
            src_idle_pct  = (phase == 2) ? 0 : 14;
            sink_idle_pct = (phase == 2) ? 0 : 14;
            phase_end = sent + PHASE_FIXES;
            while (sent < phase_end && sent < RANDOM_FIXES)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_fix(random_fix());
                    sent++;
                end
                else
                begin
                    f = route_start();
                    run_len = $urandom_range(30, 5);
                    for (int k = 0; k < run_len; k++)
                    begin
                        send_fix(f);
                        f = route_step(f);
                        sent++;
                    end
                end
            end
            phase++;
        end
        src_idle_pct  = 14;
        sink_idle_pct = 14;
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_corners();
        test_backpressure();
        test_random_stream();
        drain();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: speed_adaptive_position_ema.f
+incdir+hdl
hdl/sape_pkg.sv
hdl/sape_front.sv
hdl/sape_div.sv
hdl/sape_back.sv
hdl/speed_adaptive_position_ema.sv
test/testbench.sv
